FILE: hw/rtl/mrh_pkg.sv
`default_nettype none
package mrh_pkg;

  localparam logic [63:0] SEED       = 64'h1234_5678_9012_3456;
  localparam logic [63:0] MIX_MUL    = 64'h1402_0a57_acce_d8b7;
  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
  localparam int          ROT_LEFT   = 31;
  localparam int          ROT_RIGHT  = 33;
  localparam int          FOLD_SHIFT = 31;
  localparam logic [3:0]  WORD_BYTES = 4'd8;

endpackage
`default_nettype wire

FILE: hw/rtl/mrh_if.sv
`default_nettype none
interface mrh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        last;

  modport source (output valid, output data_word, output valid_bytes, output last,
                  input ready);
  modport sink   (input valid, input data_word, input valid_bytes, input last,
                  output ready);
endinterface

interface mrh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mrh_mul.sv
`default_nettype none
// Low 64 bits of a * MIX_MUL from three 32x32 partial products on one multiplier.
module mrh_mul
  import mrh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  output logic             done,
  output logic [63:0]      product
);

  logic        busy;
  logic [1:0]  step;
  logic [63:0] a_q;
  logic [63:0] pp;
  logic [63:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mprod;

  always_comb begin
    unique case (step)
      2'd1: begin
        ma = a_q[63:32];
        mb = MIX_MUL_LO;
      end
      2'd2: begin
        ma = a_q[31:0];
        mb = MIX_MUL_HI;
      end
      default: begin
        ma = a_q[31:0];
        mb = MIX_MUL_LO;
      end
    endcase
    mprod = 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q  <= a;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        pp   <= mprod;
        step <= step + 2'd1;
        // accumulate the product registered on the previous step
        case (step)
          2'd1: acc <= pp;
          2'd2: acc <= acc + {pp[31:0], 32'd0};
          2'd3: begin
            product <= acc + {pp[31:0], 32'd0};
            done    <= 1'b1;
            busy    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/multiply_rotate_hash_64_unit.sv
`default_nettype none
// channel  | dir | payload                          | handshake
// in_ch    | in  | data_word, valid_bytes, last     | valid / ready
// out_ch   | out | hash_value                       | valid / ready
//
// Every 64-bit multiply runs on one shared 32x32 multiplier.
// Full word: 2 multiplies. Word of n < 8 bytes: n multiplies.
// Last word adds 4 multiplies and the output state; empty non-last word: no multiply.
// rst is synchronous: hash restarts from the seed, byte count clears, output empties.
// in_ch.ready is high only while idle; a finished hash waits in the output register,
// and the next message's words are taken while it stalls.
module multiply_rotate_hash_64_unit
  import mrh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mrh_in_if.sink     in_ch,
  mrh_out_if.source  out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WX   = 3'd1;
  localparam logic [2:0] S_WH   = 3'd2;
  localparam logic [2:0] S_BYTE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state;
  logic [63:0] h;
  logic [63:0] total;
  logic [63:0] w;
  logic [63:0] x;
  logic [63:0] f;
  logic [3:0]  nbytes;
  logic [2:0]  k;
  logic [1:0]  rnd;
  logic        lastq;
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        out_valid;
  logic [63:0] out_hash;

  logic [3:0]  n_in;
  logic [63:0] h_word;
  logic [63:0] h_byte;
  logic [63:0] f_fin;
  logic [3:0]  k_inc;

  function automatic logic [63:0] rotl31(input logic [63:0] v);
    return (v << ROT_LEFT) | (v >> ROT_RIGHT);
  endfunction

  function automatic logic [63:0] fold(input logic [63:0] v);
    return v ^ (v >> FOLD_SHIFT);
  endfunction

  mrh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.hash_value = out_hash;

  assign n_in   = (in_ch.valid_bytes > WORD_BYTES) ? WORD_BYTES : in_ch.valid_bytes;
  assign h_word = rotl31(mul_prod ^ x);
  assign h_byte = mul_prod ^ {56'd0, w[{k, 3'b000} +: 8]};
  assign f_fin  = mul_prod + total;
  assign k_inc  = {1'b0, k} + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
      h         <= SEED;
      total     <= 64'd0;
    end else begin
      mul_start <= 1'b0;
      // S_OUT refills the output register itself
      if (out_valid && out_ch.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            w      <= in_ch.data_word;
            nbytes <= n_in;
            lastq  <= in_ch.last;
            total  <= total + {60'd0, n_in};
            k      <= 3'd0;
            if (n_in == WORD_BYTES) begin
              mul_a     <= in_ch.data_word;
              mul_start <= 1'b1;
              state     <= S_WX;
            end else if (n_in != 4'd0) begin
              mul_a     <= h;
              mul_start <= 1'b1;
              state     <= S_BYTE;
            end else if (in_ch.last) begin
              mul_a     <= h;
              mul_start <= 1'b1;
              state     <= S_FIN;
            end
          end
        end
        S_WX: begin
          if (mul_done) begin
            x         <= rotl31(mul_prod);
            mul_a     <= h;
            mul_start <= 1'b1;
            state     <= S_WH;
          end
        end
        S_WH: begin
          if (mul_done) begin
            h <= h_word;
            if (lastq) begin
              mul_a     <= h_word;
              mul_start <= 1'b1;
              state     <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_BYTE: begin
          if (mul_done) begin
            h <= h_byte;
            if (k_inc == nbytes) begin
              if (lastq) begin
                mul_a     <= h_byte;
                mul_start <= 1'b1;
                state     <= S_FIN;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              k         <= k + 3'd1;
              mul_a     <= h_byte;
              mul_start <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (mul_done) begin
            mul_a     <= fold(f_fin);
            mul_start <= 1'b1;
            rnd       <= 2'd0;
            state     <= S_RND;
          end
        end
        S_RND: begin
          if (mul_done) begin
            if (rnd == 2'd2) begin
              f     <= mul_prod;
              state <= S_OUT;
            end else begin
              mul_a     <= fold(mul_prod);
              mul_start <= 1'b1;
              rnd       <= rnd + 2'd1;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free, then restart from the seed
          if (!out_valid || out_ch.ready) begin
            out_hash  <= (f == 64'd0) ? 64'd1 : f;
            out_valid <= 1'b1;
            h         <= SEED;
            total     <= 64'd0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mrh_checker.sv
`default_nettype none
module mrh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [3:0]  in_valid_bytes,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_hash
);

  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hash != 64'd0))
    else $error("hash item is zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hash)))
    else $error("stalled hash item changed");

  a_busy_after_data: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_valid_bytes != 4'd0)) |=> !in_ready)
    else $error("ready while a word is being absorbed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

endmodule

bind multiply_rotate_hash_64_unit mrh_checker u_mrh_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_valid_bytes (in_ch.valid_bytes),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hash       (out_ch.hash_value)
);
`default_nettype wire

FILE: verif/multiply_rotate_hash_64_unit_test.sv
`timescale 1ns / 100ps
module multiply_rotate_hash_64_unit_test;
  import mrh_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS  = 430;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        fin;
  } word_row_t;

  localparam int DIRECTED_ROWS = 21;

  // Every row goes through the hash predictor; none has a value readable by eye.
  word_row_t directed_words [DIRECTED_ROWS] = '{
    '{64'h0000_0000_0000_0000, 4'd0,  1'b1},  // empty message right after reset
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1},
    '{64'h0000_0000_0000_0000, 4'd8,  1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0},
    '{64'hFF06_0504_0302_0100, 4'd7,  1'b1},  // top byte lies beyond the count
    '{64'hFFFF_FFFF_FFFF_FF80, 4'd1,  1'b1},
    '{64'h0123_4567_89AB_CDEF, 4'd3,  1'b0},  // partial word mid-message
    '{64'hFEDC_BA98_7654_3210, 4'd8,  1'b0},
    '{64'h5555_5555_5555_5555, 4'd0,  1'b0},  // empty word mid-message
    '{64'hAAAA_AAAA_AAAA_AAAA, 4'd15, 1'b1},  // count above eight means a full word
    '{64'h8000_0000_0000_0001, 4'd9,  1'b0},
    '{64'h0F0F_0F0F_0F0F_0F0F, 4'd2,  1'b1},
    '{64'hDEAD_BEEF_CAFE_F00D, 4'd4,  1'b0},
    '{64'h1111_2222_3333_4444, 4'd5,  1'b0},
    '{64'h7FFF_FFFF_FFFF_FFFE, 4'd6,  1'b1},
    '{64'h0000_0000_0000_0000, 4'd0,  1'b0},
    '{64'h0000_0000_0000_0000, 4'd0,  1'b1},
    '{64'h8000_0000_0000_0001, 4'd8,  1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1}
  };

  logic clk;
  logic rst;

  mrh_in_if  in_ch ();
  mrh_out_if out_ch ();

  multiply_rotate_hash_64_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [63:0] hash_state;
  logic [63:0] byte_count;
  logic [63:0] expected_hashes [$];

  int sender_idle_pct;
  int receiver_idle_pct;
  int mismatch_count;
  int hashes_checked;
  int words_sent;
  int messages_sent;
  int stall_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rotl31(input logic [63:0] v);
    return (v << ROT_LEFT) | (v >> ROT_RIGHT);
  endfunction

  // Fold one accepted word into the running hash; queue the digest on the last word.
  function automatic void absorb_word_item(input logic [63:0] w, input logic [3:0] n_in,
                                           input logic fin);
    logic [63:0] h;
    logic [3:0]  n;
    int          k;
    n = (n_in > WORD_BYTES) ? WORD_BYTES : n_in;
    if (n == WORD_BYTES) begin
      hash_state = rotl31((hash_state * MIX_MUL) ^ rotl31(w * MIX_MUL));
    end else begin
      for (k = 0; k < n; k++) begin
        hash_state = (hash_state * MIX_MUL) ^ {56'd0, w[8*k +: 8]};
      end
    end
    byte_count = byte_count + {60'd0, n};
    if (fin) begin
      h = hash_state * MIX_MUL + byte_count;
      for (k = 0; k < 3; k++) begin
        h = h ^ (h >> FOLD_SHIFT);
        h = h * MIX_MUL;
      end
      if (h == 64'd0) begin
        h = 64'd1;
      end
      expected_hashes.push_back(h);
      hash_state = SEED;
      byte_count = 64'd0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic fin);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid       = 1'b0;
      in_ch.data_word   = {$urandom(), $urandom()};
      in_ch.valid_bytes = 4'($urandom_range(0, 15));
      in_ch.last        = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.data_word   = w;
    in_ch.valid_bytes = n;
    in_ch.last        = fin;
    do @(posedge clk); while (!in_ch.ready);
    absorb_word_item(w, n, fin);
    words_sent++;
    if (fin) begin
      messages_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_random_message();
    int         word_total;
    int         i;
    logic [3:0] tail_bytes;
    if ($urandom_range(0, 99) < 85) begin
      word_total = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
      for (i = 0; i < word_total; i++) begin
        send_word({$urandom(), $urandom()}, WORD_BYTES, 1'b0);
      end
      tail_bytes = 4'($urandom_range(0, 8));
    end else begin
      // broken message: partial, empty and oversized counts before the end
      word_total = $urandom_range(1, 4);
      for (i = 0; i < word_total; i++) begin
        send_word({$urandom(), $urandom()}, 4'($urandom_range(0, 15)), 1'b0);
      end
      tail_bytes = 4'($urandom_range(0, 15));
    end
    send_word({$urandom(), $urandom()}, tail_bytes, 1'b1);
  endtask

  // Hold the sender until every queued digest has come back, then let the block settle.
  task automatic drain_hashes();
    in_ch.valid = 1'b0;
    while (expected_hashes.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      out_ch.ready = ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hashes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected hash %h with nothing pending", out_ch.hash_value);
          end
        end else begin
          want = expected_hashes.pop_front();
          hashes_checked++;
          if (out_ch.hash_value !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("hash mismatch: expected %h, got %h", want, out_ch.hash_value);
            end
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
          $display("multiply_rotate_hash_64_unit_test: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int phase;
    int row;
    int phase_target;
    clk               = 1'b0;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.data_word   = 64'd0;
    in_ch.valid_bytes = 4'd0;
    in_ch.last        = 1'b0;
    out_ch.ready      = 1'b0;
    hash_state        = SEED;
    byte_count        = 64'd0;
    mismatch_count    = 0;
    hashes_checked    = 0;
    words_sent        = 0;
    messages_sent     = 0;
    stall_cycles      = 0;
    sender_idle_pct   = 22;
    receiver_idle_pct = 77;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_word(directed_words[row].word, directed_words[row].nbytes,
                directed_words[row].fin);
    end
    drain_hashes();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 22;
          receiver_idle_pct = 77;
        end
        1: begin
          sender_idle_pct   = 77;
          receiver_idle_pct = 22;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      phase_target = words_sent + RANDOM_ITEMS / 3;
      while (words_sent < phase_target) begin
        send_random_message();
      end
      drain_hashes();
    end

    $display("covered %0d messages in %0d words under three idle patterns;", messages_sent,
             words_sent);
    $display("%0d digests compared, %0d mismatches", hashes_checked, mismatch_count);
    if (mismatch_count == 0 && expected_hashes.size() == 0) begin
      $display("multiply_rotate_hash_64_unit_test: clean");
    end else begin
      $display("multiply_rotate_hash_64_unit_test: errors");
    end
    $finish;
  end

endmodule
